### rtl/gdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg: shared definitions for the GTP decapsulation classifier
// Table geometry, verdict codes, GTP header constants and the types that
// pass between the classifier control and the context table.
// ----------------------------------------------------------------------------
package gdc_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Verdict codes
   localparam logic [2:0] VERD_FORWARD = 3'd0;
   localparam logic [2:0] VERD_DROP    = 3'd1;
   localparam logic [2:0] VERD_HOST    = 3'd2;
   localparam logic [2:0] VERD_ADDED   = 3'd3;
   localparam logic [2:0] VERD_FULL    = 3'd4;

   // Action codes
   localparam logic ACT_CLASSIFY = 1'b0;
   localparam logic ACT_ADD      = 1'b1;

   // Header versions
   localparam logic       VER_V0      = 1'b0;
   localparam logic       VER_V1      = 1'b1;
   localparam logic [2:0] HDR_VER_V0  = 3'd0;
   localparam logic [2:0] HDR_VER_V1  = 3'd1;

   // GTP header constants
   localparam logic [7:0]  TPDU_TYPE = 8'd255;
   localparam logic [4:0]  V0_STRIP  = 5'd28;
   localparam logic [4:0]  V1_STRIP  = 5'd16;
   localparam logic [7:0]  FLAG_NPDU = 8'h01;
   localparam logic [7:0]  FLAG_SEQ  = 8'h02;
   localparam logic [7:0]  FLAG_EXT  = 8'h04;

   // One tunnel context as stored in the table
   typedef struct packed {
      logic        ver;
      logic [63:0] tid;
   } entry_type;

   // Write request into the context table
   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type entry;
   } tbl_wr_type;

   // Read request into the context table
   typedef struct packed {
      logic    en;
      idx_type addr;
   } tbl_rd_type;

   // Reduce a table index to the 8-bit result field
   function automatic logic [7:0] idx_to_field(input idx_type idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[7:0];
   endfunction

endpackage
`default_nettype wire

### rtl/gdc_ctx_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_ctx_table: tunnel context memory with compare
// One write port and one registered read port. The entry read in the
// previous cycle is compared against the search key.
// ----------------------------------------------------------------------------
module gdc_ctx_table (
   input  wire logic               clock,
   input  wire gdc_pkg::tbl_wr_type wr,
   input  wire gdc_pkg::tbl_rd_type rd,
   input  wire logic               key_ver,
   input  wire logic [63:0]        key_tid,
   output logic                    hit
);
   import gdc_pkg::*;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   // Write a context, read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   // Match the entry read last cycle against the key
   assign hit = (rd_data_ff.ver == key_ver) && (rd_data_ff.tid == key_tid);

endmodule
`default_nettype wire

### rtl/gtp_decap_classifier.sv
`default_nettype none
// Result path: add, table full, header rejects and an empty table go straight to the wait
//   state; a search reads one entry per cycle from zero until a hit or the last filled entry.
// Throughput: one item at a time; no request is taken until the result leaves the wait
//   state, which it does once the response register is free.
// Reset: synchronous, clears the fill count, the state and the result valid; the
//   table memory is not cleared, entries at or above the fill count are never read.
// ----------------------------------------------------------------------------
// gtp_decap_classifier: GTP-U tunnel lookup and receive header checks
// Adds tunnel contexts to a table and classifies received GTP headers
// against the v0 or v1 receive rules with a linear table search.
// ----------------------------------------------------------------------------
module gtp_decap_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic        req_tunnel_ver,
   input  wire logic [7:0]  req_gtp_flags,
   input  wire logic [7:0]  req_msg_type,
   input  wire logic [63:0] req_tunnel_id,
   input  wire logic [15:0] req_packet_len,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_verdict,
   output logic [4:0]       rsp_strip_len,
   output logic [7:0]       rsp_match_index
);
   import gdc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    fill_ff, fill_in;
   idx_type    cmp_idx_ff, cmp_idx_in;
   logic       key_ver_ff, key_ver_in;
   logic [63:0] key_tid_ff, key_tid_in;
   logic [2:0] pend_verdict_ff, pend_verdict_in;
   logic [4:0] pend_strip_ff, pend_strip_in;
   logic [7:0] pend_index_ff, pend_index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_verdict_ff, rsp_verdict_in;
   logic [4:0] rsp_strip_ff, rsp_strip_in;
   logic [7:0] rsp_index_ff, rsp_index_in;

   logic        req_acc;
   logic        table_full;
   logic        v0_bad;
   logic        v1_bad;
   logic [15:0] v1_need;
   logic [63:0] req_key_tid;
   logic        last_entry;
   logic        out_free;
   logic        hit;
   tbl_wr_type  tbl_wr;
   tbl_rd_type  tbl_rd;

   gdc_ctx_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .key_ver (key_ver_ff),
      .key_tid (key_tid_ff),
      .hit     (hit)
   );

   // Handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Header checks and key
   assign table_full  = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign v0_bad      = (req_packet_len < 16'(V0_STRIP)) || (req_gtp_flags[7:5] != HDR_VER_V0)
                        || (req_msg_type != TPDU_TYPE);
   assign v1_need     = 16'(V1_STRIP)
                        + (|(req_gtp_flags & FLAG_SEQ)  ? 16'd2 : 16'd0)
                        + (|(req_gtp_flags & FLAG_NPDU) ? 16'd1 : 16'd0)
                        + (|(req_gtp_flags & FLAG_EXT)  ? 16'd1 : 16'd0);
   assign v1_bad      = (req_packet_len < 16'(V1_STRIP)) || (req_gtp_flags[7:5] != HDR_VER_V1)
                        || (req_msg_type != TPDU_TYPE) || (req_packet_len < v1_need);
   assign req_key_tid = (req_tunnel_ver == VER_V1) ? {32'd0, req_tunnel_id[31:0]}
                                                   : req_tunnel_id;
   assign last_entry  = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == fill_ff);

   // Control: dispatch, scan, hand the result to the output register
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      cmp_idx_in      = cmp_idx_ff;
      key_ver_in      = key_ver_ff;
      key_tid_in      = key_tid_ff;
      pend_verdict_in = pend_verdict_ff;
      pend_strip_in   = pend_strip_ff;
      pend_index_in   = pend_index_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_strip_in    = rsp_strip_ff;
      rsp_index_in    = rsp_index_ff;
      tbl_wr.en       = 1'b0;
      tbl_wr.addr     = fill_ff[IDX_W-1:0];
      tbl_wr.entry    = '{ver: req_tunnel_ver, tid: req_key_tid};
      tbl_rd.en       = 1'b0;
      tbl_rd.addr     = cmp_idx_ff + idx_type'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pend_strip_in = 5'd0;
               pend_index_in = 8'd0;
               key_ver_in    = req_tunnel_ver;
               key_tid_in    = req_key_tid;
               state_in      = ST_WAIT;
               if (req_action == ACT_ADD) begin
                  if (table_full) begin
                     pend_verdict_in = VERD_FULL;
                  end else begin
                     tbl_wr.en       = 1'b1;
                     pend_verdict_in = VERD_ADDED;
                     pend_index_in   = idx_to_field(fill_ff[IDX_W-1:0]);
                     fill_in         = fill_ff + CNT_W'(1);
                  end
               end else if ((req_tunnel_ver == VER_V0) &&
                            ((req_packet_len < 16'(V0_STRIP)) ||
                             (req_gtp_flags[7:5] != HDR_VER_V0))) begin
                  pend_verdict_in = VERD_DROP;
               end else if ((req_tunnel_ver == VER_V0) && v0_bad) begin
                  // well-formed v0 signaling goes to the host
                  pend_verdict_in = VERD_HOST;
               end else if ((req_tunnel_ver == VER_V1) && v1_bad) begin
                  pend_verdict_in = VERD_DROP;
               end else if (fill_ff == '0) begin
                  pend_verdict_in = VERD_DROP;
               end else begin
                  // start the search at entry zero
                  tbl_rd.en   = 1'b1;
                  tbl_rd.addr = '0;
                  cmp_idx_in  = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               pend_verdict_in = VERD_FORWARD;
               pend_strip_in   = (key_ver_ff == VER_V1) ? V1_STRIP : V0_STRIP;
               pend_index_in   = idx_to_field(cmp_idx_ff);
               state_in        = ST_WAIT;
            end else if (last_entry) begin
               pend_verdict_in = VERD_DROP;
               state_in        = ST_WAIT;
            end else begin
               // advance to the next entry
               tbl_rd.en  = 1'b1;
               cmp_idx_in = cmp_idx_ff + idx_type'(1);
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = pend_verdict_ff;
               rsp_strip_in   = pend_strip_ff;
               rsp_index_in   = pend_index_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff      <= cmp_idx_in;
      key_ver_ff      <= key_ver_in;
      key_tid_ff      <= key_tid_in;
      pend_verdict_ff <= pend_verdict_in;
      pend_strip_ff   <= pend_strip_in;
      pend_index_ff   <= pend_index_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_strip_ff    <= rsp_strip_in;
      rsp_index_ff    <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_strip_len   = rsp_strip_ff;
   assign rsp_match_index = rsp_index_ff;

   // Fill count never passes the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   // A search only looks at entries that were written
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(cmp_idx_ff) < fill_ff))
      else $error("search past the filled entries");

   // An add into a table with room grows the fill count by one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_action == ACT_ADD) && !table_full)
         |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("add did not advance the fill count");

   // A forward result always carries a strip length
   a_fwd_strip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_verdict_ff == VERD_FORWARD)) |-> (rsp_strip_ff != 5'd0))
      else $error("forward without strip length");

endmodule
`default_nettype wire
